FILE: hdl/bcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bcs_pkg
// Shared types, register codes and datapath step functions of the
// Brooks-Corey saturation evaluation pipeline.
// ============================================================================
package bcs_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_RESIDUAL_LIQUID = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESIDUAL_GAS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_EXPONENT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AIR_ENTRY       = 3'd3;

  localparam logic [15:0] RESIDUAL_LIQUID_RST = 16'd0;
  localparam logic [15:0] RESIDUAL_GAS_RST    = 16'd0;
  localparam logic [15:0] SHAPE_EXPONENT_RST  = 16'd8192;
  localparam logic [30:0] AIR_ENTRY_RST       = 31'd10000;

  // pipeline section lengths
  localparam int D1_STAGES  = 32;   // entry ratio pb/p, Q0.32
  localparam int INT_STAGES = 15;   // integer part of the exponent
  localparam int FRAC_BITS  = 12;   // fraction bits of the exponent
  localparam int SQ_STAGES  = 32;   // one root bit per stage
  localparam int PW_LAST    = INT_STAGES + FRAC_BITS * (SQ_STAGES + 1);
  localparam int DA_STAGES  = 64;   // 64 bit dividend by pressure
  localparam int DR_STAGES  = 48;   // remainder term of the curvature

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [16:0] ONE_Q16 = 17'h1_0000;
  localparam logic [16:0] M_BIAS  = 17'd4096;

  typedef struct packed {
    logic [15:0] residual_liquid;
    logic [15:0] residual_gas;
    logic [15:0] shape_exponent;
    logic [30:0] air_entry;
  } cfg_t;

  // divider section stage
  typedef struct packed {
    logic        v;
    logic        flat;
    logic        neg;
    logic [30:0] p;
    logic [16:0] sat;
    logic [43:0] mag;
    logic [63:0] keep;
    logic [63:0] num;
    logic [30:0] rem;
    logic [63:0] quo;
  } dv_t;

  // power section stage
  typedef struct packed {
    logic        v;
    logic        flat;
    logic [30:0] p;
    logic [32:0] e;
    logic [31:0] q;
    logic [33:0] rem;
    logic [31:0] root;
  } pw_t;

  typedef struct packed {
    logic        v;
    logic        flat;
    logic [30:0] p;
    logic [49:0] sd;
    logic [48:0] le;
  } p1_t;

  typedef struct packed {
    logic        v;
    logic        flat;
    logic        neg;
    logic [16:0] sat;
    logic [43:0] mag;
    logic [56:0] hi;
    logic [48:0] lo;
  } p4_t;

  typedef struct packed {
    logic        v;
    logic [16:0] saturation;
    logic [47:0] slope;
    logic [62:0] curvature;
  } res_t;

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [31:0] div_step(input logic [30:0] rem, input logic b,
                                           input logic [30:0] d);
    logic [31:0] sh;
    logic [31:0] df;
    sh = {rem, b};
    df = sh - {1'b0, d};
    if (sh >= {1'b0, d}) begin
      div_step = {1'b1, df[30:0]};
    end else begin
      div_step = {1'b0, sh[30:0]};
    end
  endfunction

  // one digit of an integer square root: {new root, new remainder}
  function automatic logic [65:0] sqrt_step(input logic [33:0] rem, input logic [31:0] root,
                                            input logic [1:0] bits);
    logic [35:0] sh;
    logic [35:0] tr;
    logic [35:0] df;
    sh = {rem, bits};
    tr = {2'b00, root, 2'b01};
    df = sh - tr;
    if (sh >= tr) begin
      sqrt_step = {root[30:0], 1'b1, df[33:0]};
    end else begin
      sqrt_step = {root[30:0], 1'b0, sh[33:0]};
    end
  endfunction

endpackage
`default_nettype wire

FILE: hdl/bcs_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bcs_in_if
// Pressure input channel: valid/ready with one capillary pressure.
// ============================================================================
interface bcs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cap_pressure;

  modport source(output valid, output cap_pressure, input ready);
  modport sink(input valid, input cap_pressure, output ready);
endinterface
`default_nettype wire

FILE: hdl/bcs_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bcs_out_if
// Result channel: valid/ready with saturation and its two derivatives.
// ============================================================================
interface bcs_out_if;
  logic               valid;
  logic               ready;
  logic        [16:0] saturation;
  logic signed [47:0] slope;
  logic        [62:0] curvature;

  modport source(output valid, output saturation, output slope, output curvature,
                 input ready);
  modport sink(input valid, input saturation, input slope, input curvature,
               output ready);
endinterface
`default_nettype wire

FILE: hdl/bcs_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bcs_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ============================================================================
interface bcs_cfg_if;
  import bcs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/brooks_corey_saturation_eval_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// brooks_corey_saturation_eval_unit
// Brooks-Corey liquid saturation with first and second pressure derivative.
// ============================================================================
// Usage:
//   in_ch  : one capillary pressure per transfer (valid/ready).
//   out_ch : saturation (Q1.16), slope (2^-40/Pa), curvature (2^-48/Pa^2)
//            per transfer, one result for every pressure, in order.
//   cfg_ch : register writes (index, data), always ready; write only while
//            no pressure is in flight.
//   Throughput: one pressure per cycle while the pipeline is not frozen.
//   The pipeline holds the 32-step ratio divider, twelve 32-step square
//   root units of the power chain, the two 64-step and one 48-step
//   dividers of the derivatives, and the output register.
//   Reset (rst_n low, synchronous) loads the default registers and empties
//   the pipeline. When the receiver stalls the output register holds; the
//   pipeline keeps accepting while its last stage is empty and freezes as a
//   whole once a result waits behind the held one.
// ============================================================================
module brooks_corey_saturation_eval_unit (
  input wire logic  clk,
  input wire logic  rst_n,
  bcs_in_if.sink    in_ch,
  bcs_out_if.source out_ch,
  bcs_cfg_if.sink   cfg_ch
);
  import bcs_pkg::*;

  cfg_t cfg_r;
  res_t res;
  res_t out_r;
  logic out_valid_r;
  logic en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.residual_liquid <= RESIDUAL_LIQUID_RST;
      cfg_r.residual_gas    <= RESIDUAL_GAS_RST;
      cfg_r.shape_exponent  <= SHAPE_EXPONENT_RST;
      cfg_r.air_entry       <= AIR_ENTRY_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_RESIDUAL_LIQUID: cfg_r.residual_liquid <= cfg_ch.data[15:0];
        REG_RESIDUAL_GAS:    cfg_r.residual_gas    <= cfg_ch.data[15:0];
        REG_SHAPE_EXPONENT:  cfg_r.shape_exponent  <= cfg_ch.data[15:0];
        REG_AIR_ENTRY:       cfg_r.air_entry       <= cfg_ch.data[30:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // pipeline moves unless a finished result is blocked by the held output
  assign en          = !res.v || !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  bcs_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .in_valid        (in_ch.valid),
    .in_cap_pressure (in_ch.cap_pressure),
    .cfg             (cfg_r),
    .res             (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= res.v;
      out_r       <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.saturation = out_r.saturation;
  assign out_ch.slope      = out_r.slope;
  assign out_ch.curvature  = out_r.curvature;

endmodule
`default_nettype wire

FILE: hdl/bcs_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bcs_core
// Stall-enabled datapath pipeline: ratio divider, power chain with square
// root units, scaling multipliers and derivative dividers.
// ============================================================================
module bcs_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [31:0]    in_cap_pressure,
  input  wire bcs_pkg::cfg_t  cfg,
  output bcs_pkg::res_t       res
);
  import bcs_pkg::*;

  dv_t d1_r  [0:D1_STAGES];
  dv_t d1_nxt[0:D1_STAGES];
  pw_t pw_r  [0:PW_LAST];
  pw_t pw_nxt[0:PW_LAST];
  dv_t da_r  [0:DA_STAGES];
  dv_t da_nxt[0:DA_STAGES];
  dv_t dq_r  [0:DA_STAGES];
  dv_t dq_nxt[0:DA_STAGES];
  dv_t dr_r  [0:DR_STAGES];
  dv_t dr_nxt[0:DR_STAGES];
  p1_t  p1_r,  p1_nxt;
  p4_t  p4_r,  p4_nxt;
  res_t res_r, res_nxt;

  logic [16:0] smax;
  logic        neg;
  logic [16:0] dmag;
  logic [16:0] m_fac;

  // values that follow from configuration alone
  always_comb begin
    smax  = ONE_Q16 - {1'b0, cfg.residual_gas};
    neg   = {1'b0, cfg.residual_liquid} > smax;
    dmag  = neg ? ({1'b0, cfg.residual_liquid} - smax) : (smax - {1'b0, cfg.residual_liquid});
    m_fac = {1'b0, cfg.shape_exponent} + M_BIAS;
  end

  // entry: flat region test, ratio divider seeded with the entry pressure
  always_comb begin
    d1_nxt[0]      = '0;
    d1_nxt[0].v    = in_valid;
    d1_nxt[0].flat = in_cap_pressure[31] || (in_cap_pressure[30:0] <= cfg.air_entry);
    d1_nxt[0].p    = in_cap_pressure[30:0];
    d1_nxt[0].rem  = cfg.air_entry;
  end

  genvar gi, gf, gj;

  // ratio pb*2^32/p, one quotient bit per stage
  for (gi = 0; gi < D1_STAGES; gi++) begin : g_d1
    logic [31:0] st;
    always_comb begin
      st                 = div_step(d1_r[gi].rem, 1'b0, d1_r[gi].p);
      d1_nxt[gi+1]       = d1_r[gi];
      d1_nxt[gi+1].rem   = st[30:0];
      d1_nxt[gi+1].quo   = {d1_r[gi].quo[62:0], st[31]};
    end
  end

  // power chain seed: e = one, q = ratio
  always_comb begin
    pw_nxt[0]      = '0;
    pw_nxt[0].v    = d1_r[D1_STAGES].v;
    pw_nxt[0].flat = d1_r[D1_STAGES].flat;
    pw_nxt[0].p    = d1_r[D1_STAGES].p;
    pw_nxt[0].e    = ONE_Q32;
    pw_nxt[0].q    = d1_r[D1_STAGES].quo[31:0];
  end

  // integer part of the exponent: conditional multiply by the ratio
  for (gi = 0; gi < INT_STAGES; gi++) begin : g_int
    logic [64:0] prod;
    always_comb begin
      prod         = 65'(pw_r[gi].e) * 65'(pw_r[gi].q);
      pw_nxt[gi+1] = pw_r[gi];
      if (4'(gi) < cfg.shape_exponent[15:12]) begin
        pw_nxt[gi+1].e = prod[64:32];
      end
    end
  end

  // fraction bits: square root of the ratio or the previous root, then conditional multiply
  for (gf = 0; gf < FRAC_BITS; gf++) begin : g_frac
    localparam int BASE = INT_STAGES + gf * (SQ_STAGES + 1);
    localparam int MIDX = BASE + SQ_STAGES;
    logic [64:0] prod;
    for (gj = 0; gj < SQ_STAGES; gj++) begin : g_sq
      logic [1:0]  bits;
      logic [65:0] st;
      if (gj < SQ_STAGES / 2) begin : g_hi
        assign bits = pw_r[BASE+gj].q[31-2*gj -: 2];
      end else begin : g_lo
        assign bits = 2'b00;
      end
      always_comb begin
        st                     = sqrt_step(pw_r[BASE+gj].rem, pw_r[BASE+gj].root, bits);
        pw_nxt[BASE+gj+1]      = pw_r[BASE+gj];
        pw_nxt[BASE+gj+1].root = st[65:34];
        pw_nxt[BASE+gj+1].rem  = st[33:0];
      end
    end
    always_comb begin
      prod              = 65'(pw_r[MIDX].e) * 65'(pw_r[MIDX].root);
      pw_nxt[MIDX+1]      = pw_r[MIDX];
      pw_nxt[MIDX+1].q    = pw_r[MIDX].root;
      pw_nxt[MIDX+1].rem  = '0;
      pw_nxt[MIDX+1].root = '0;
      if (cfg.shape_exponent[FRAC_BITS-1-gf]) begin
        pw_nxt[MIDX+1].e = prod[64:32];
      end
    end
  end

  // scale by span and exponent
  always_comb begin
    p1_nxt.v    = pw_r[PW_LAST].v;
    p1_nxt.flat = pw_r[PW_LAST].flat;
    p1_nxt.p    = pw_r[PW_LAST].p;
    p1_nxt.sd   = 50'(pw_r[PW_LAST].e) * 50'(dmag);
    p1_nxt.le   = 49'(cfg.shape_exponent) * 49'(pw_r[PW_LAST].e);
  end

  // rounded saturation and slope dividend
  logic [50:0] sd_rnd;
  logic [65:0] num_full;
  always_comb begin
    sd_rnd         = {1'b0, p1_r.sd} + 51'h0_8000_0000;
    num_full       = 66'(p1_r.le) * 66'(dmag);
    da_nxt[0]      = '0;
    da_nxt[0].v    = p1_r.v;
    da_nxt[0].flat = p1_r.flat;
    da_nxt[0].neg  = neg;
    da_nxt[0].p    = p1_r.p;
    da_nxt[0].sat  = neg ? ({1'b0, cfg.residual_liquid} - sd_rnd[48:32])
                         : ({1'b0, cfg.residual_liquid} + sd_rnd[48:32]);
    da_nxt[0].num  = num_full[63:0];
  end

  // A = lambda*E*D / p
  for (gi = 0; gi < DA_STAGES; gi++) begin : g_da
    logic [31:0] st;
    always_comb begin
      st               = div_step(da_r[gi].rem, da_r[gi].num[63-gi], da_r[gi].p);
      da_nxt[gi+1]     = da_r[gi];
      da_nxt[gi+1].rem = st[30:0];
      da_nxt[gi+1].quo = {da_r[gi].quo[62:0], st[31]};
    end
  end

  always_comb begin
    dq_nxt[0]     = da_r[DA_STAGES];
    dq_nxt[0].mag = da_r[DA_STAGES].quo[63:20];
    dq_nxt[0].num = da_r[DA_STAGES].quo;
    dq_nxt[0].rem = '0;
    dq_nxt[0].quo = '0;
  end

  // A / p with remainder
  for (gi = 0; gi < DA_STAGES; gi++) begin : g_dq
    logic [31:0] st;
    always_comb begin
      st               = div_step(dq_r[gi].rem, dq_r[gi].num[63-gi], dq_r[gi].p);
      dq_nxt[gi+1]     = dq_r[gi];
      dq_nxt[gi+1].rem = st[30:0];
      dq_nxt[gi+1].quo = {dq_r[gi].quo[62:0], st[31]};
    end
  end

  // remainder times (lambda + one)
  logic [47:0] rmm;
  always_comb begin
    rmm            = 48'(dq_r[DA_STAGES].rem) * 48'(m_fac);
    dr_nxt[0]      = dq_r[DA_STAGES];
    dr_nxt[0].keep = dq_r[DA_STAGES].quo;
    dr_nxt[0].num  = {rmm, 16'h0000};
    dr_nxt[0].rem  = '0;
    dr_nxt[0].quo  = '0;
  end

  for (gi = 0; gi < DR_STAGES; gi++) begin : g_dr
    logic [31:0] st;
    always_comb begin
      st               = div_step(dr_r[gi].rem, dr_r[gi].num[63-gi], dr_r[gi].p);
      dr_nxt[gi+1]     = dr_r[gi];
      dr_nxt[gi+1].rem = st[30:0];
      dr_nxt[gi+1].quo = {dr_r[gi].quo[62:0], st[31]};
    end
  end

  // curvature partial products
  always_comb begin
    p4_nxt.v    = dr_r[DR_STAGES].v;
    p4_nxt.flat = dr_r[DR_STAGES].flat;
    p4_nxt.neg  = dr_r[DR_STAGES].neg;
    p4_nxt.sat  = dr_r[DR_STAGES].sat;
    p4_nxt.mag  = dr_r[DR_STAGES].mag;
    p4_nxt.hi   = 57'(dr_r[DR_STAGES].keep[63:24]) * 57'(m_fac);
    p4_nxt.lo   = 49'(dr_r[DR_STAGES].keep[23:0]) * 49'(m_fac)
                + 49'(dr_r[DR_STAGES].quo[47:0]);
  end

  // final assembly, flat region overrides
  logic [57:0] curv;
  always_comb begin
    curv      = {1'b0, p4_r.hi} + 58'(p4_r.lo[48:24]);
    res_nxt.v = p4_r.v;
    if (p4_r.flat) begin
      res_nxt.saturation = smax;
      res_nxt.slope      = '0;
      res_nxt.curvature  = '0;
    end else begin
      res_nxt.saturation = p4_r.sat;
      res_nxt.slope      = p4_r.neg ? 48'(p4_r.mag) : (48'd0 - 48'(p4_r.mag));
      res_nxt.curvature  = p4_r.neg ? 63'd0 : 63'(curv);
    end
  end

  // stage registers, valid bits cleared by reset
  for (gi = 0; gi <= D1_STAGES; gi++) begin : g_d1_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d1_r[gi].v <= 1'b0;
      end else if (en) begin
        d1_r[gi] <= d1_nxt[gi];
      end
    end
  end

  for (gi = 0; gi <= PW_LAST; gi++) begin : g_pw_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pw_r[gi].v <= 1'b0;
      end else if (en) begin
        pw_r[gi] <= pw_nxt[gi];
      end
    end
  end

  for (gi = 0; gi <= DA_STAGES; gi++) begin : g_dd_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        da_r[gi].v <= 1'b0;
        dq_r[gi].v <= 1'b0;
      end else if (en) begin
        da_r[gi] <= da_nxt[gi];
        dq_r[gi] <= dq_nxt[gi];
      end
    end
  end

  for (gi = 0; gi <= DR_STAGES; gi++) begin : g_dr_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dr_r[gi].v <= 1'b0;
      end else if (en) begin
        dr_r[gi] <= dr_nxt[gi];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r.v  <= 1'b0;
      p4_r.v  <= 1'b0;
      res_r.v <= 1'b0;
    end else if (en) begin
      p1_r  <= p1_nxt;
      p4_r  <= p4_nxt;
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

FILE: hdl/bcs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bcs_checker
// Port-level checks of the saturation unit, bound to the top level.
// ============================================================================
module bcs_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic        [16:0] saturation,
  input wire logic signed [47:0] slope,
  input wire logic        [62:0] curvature
);

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a pending result is not withdrawn
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // an empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // saturation never exceeds one
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> saturation <= 17'h1_0000)
    else $error("saturation above one");

  // positive curvature only on a falling curve
  a_curv_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && curvature != 63'd0 |-> slope[47] || slope == 48'sd0)
    else $error("curvature with rising slope");

endmodule

bind brooks_corey_saturation_eval_unit bcs_checker u_bcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .saturation (out_ch.saturation),
  .slope      (out_ch.slope),
  .curvature  (out_ch.curvature)
);
`default_nettype wire
